// ===== rtl/core/rwb_pkg.sv =====
package rwb_pkg;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int EXP_W    = 3;
   localparam int COEF_W   = 20;
   localparam int HIST_W   = 32;
   localparam int POW_W    = 25;
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int GACC_W   = 44;
   localparam int FACC_W   = 56;
   localparam int Y_W      = FACC_W - 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [POW_W-1:0] ONE_Q23 = 25'sh0800000;

   localparam logic signed [GAIN_W-1:0] POWER_GAIN_RST  = 16'sd8192;
   localparam logic [EXP_W-1:0]         POWER_EXP_RST   = 3'd5;
   localparam logic signed [GAIN_W-1:0] CUBE_GAIN_RST   = 16'sd20480;
   localparam logic signed [GAIN_W-1:0] LINEAR_GAIN_RST = 16'sd12288;

   localparam logic [CSR_IDX_W-1:0] REG_POWER_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_EXP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CUBE_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B0     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B2     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A1     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A2     = 3'd7;

   typedef struct packed {
      logic signed [GAIN_W-1:0] power_gain;
      logic [EXP_W-1:0]         power_exponent;
      logic signed [GAIN_W-1:0] cube_gain;
      logic signed [GAIN_W-1:0] linear_gain;
      logic signed [COEF_W-1:0] coef_b0;
      logic signed [COEF_W-1:0] coef_b2;
      logic signed [COEF_W-1:0] coef_a1;
      logic signed [COEF_W-1:0] coef_a2;
   } cfg_type;

   typedef struct packed {
      logic                       bypass;
      logic signed [SAMPLE_W-1:0] sample;
   } entry_type;

endpackage

// ===== rtl/core/rwb_front.sv =====
module rwb_front import rwb_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_process_enable,
   input  logic                       pop,
   output logic                       head_valid,
   output entry_type                  head
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

   entry_type       entries_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   entry_type       entry_in;
   logic            push;

   assign req_ready  = (count_ff != FullCnt);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   // zero samples and disabled requests skip the effect
   always_comb begin
      entry_in.bypass = !req_process_enable || (req_sample_in == '0);
      entry_in.sample = req_sample_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== rtl/core/rwb_back.sv =====
module rwb_back import rwb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       head_valid,
   input  entry_type                  head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POW  = 3'd1;
   localparam logic [2:0] ST_GAIN = 3'd2;
   localparam logic [2:0] ST_FILT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] ST_PASS = 3'd5;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [Y_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v[Y_W-1:SAMPLE_W-1] == {(Y_W-SAMPLE_W+1){v[Y_W-1]}}) begin
         r = v[SAMPLE_W-1:0];
      end else begin
         r = v[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [HIST_W-1:0] sat32(input logic signed [Y_W-1:0] v);
      logic signed [HIST_W-1:0] r;
      if (v[Y_W-1:HIST_W-1] == {(Y_W-HIST_W+1){v[Y_W-1]}}) begin
         r = v[HIST_W-1:0];
      end else begin
         r = v[Y_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
      end
      return r;
   endfunction

   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 step_ff, step_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [POW_W-1:0]    pow_ff, pow_in;
   logic signed [POW_W-1:0]    cube_ff, cube_in;
   logic signed [GACC_W-1:0]   gacc_ff, gacc_in;
   logic signed [FACC_W-1:0]   facc_ff, facc_in;
   logic signed [HIST_W-1:0]   s_ff, s_in;
   logic signed [HIST_W-1:0]   sh1_ff, sh1_in, sh2_ff, sh2_in;
   logic signed [HIST_W-1:0]   oh1_ff, oh1_in, oh2_ff, oh2_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic signed [MUL_A_W-1:0]  op_a;
   logic signed [MUL_B_W-1:0]  op_b;
   logic signed [POW_W-1:0]    cur;
   logic [EXP_W-1:0]           last_k;
   logic signed [GACC_W-1:0]   prod_g;
   logic signed [FACC_W-1:0]   prod_f;
   logic signed [HIST_W-1:0]   s_now;
   logic signed [Y_W-1:0]      y;
   logic                       out_free;

   assign cur      = (step_ff == '0) ? ONE_Q23 : $signed(prod_ff[23+POW_W-1:23]);
   assign last_k   = (cfg.power_exponent > EXP_W'(3)) ? cfg.power_exponent : EXP_W'(3);
   assign prod_g   = prod_ff[GACC_W-1:0];
   assign prod_f   = prod_ff[FACC_W-1:0];
   assign s_now    = gacc_ff[12+HIST_W-1:12];
   assign y        = facc_ff[FACC_W-1:16];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign prod_in  = op_a * op_b;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      x_in          = x_ff;
      pow_in        = pow_ff;
      cube_in       = cube_ff;
      gacc_in       = gacc_ff;
      facc_in       = facc_ff;
      s_in          = s_ff;
      sh1_in        = sh1_ff;
      sh2_in        = sh2_ff;
      oh1_in        = oh1_ff;
      oh2_in        = oh2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      op_a          = '0;
      op_b          = '0;
      pop           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               x_in     = head.sample;
               step_in  = '0;
               state_in = head.bypass ? ST_PASS : ST_POW;
            end
         end
         // repeated multiply by x, power and cube picked off on the way
         ST_POW: begin
            op_a = {{(MUL_A_W-POW_W){cur[POW_W-1]}}, cur};
            op_b = {{(MUL_B_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
            if (step_ff == 3'd3) begin
               cube_in = cur;
            end
            if (step_ff == cfg.power_exponent) begin
               pow_in = cur;
            end
            if (step_ff == last_k) begin
               state_in = ST_GAIN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_GAIN: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd0: begin
                  op_a = {{(MUL_A_W-POW_W){pow_ff[POW_W-1]}}, pow_ff};
                  op_b = {{(MUL_B_W-GAIN_W){cfg.power_gain[GAIN_W-1]}}, cfg.power_gain};
               end
               3'd1: begin
                  op_a    = {{(MUL_A_W-POW_W){cube_ff[POW_W-1]}}, cube_ff};
                  op_b    = {{(MUL_B_W-GAIN_W){cfg.cube_gain[GAIN_W-1]}}, cfg.cube_gain};
                  gacc_in = prod_g;
               end
               3'd2: begin
                  op_a    = {{(MUL_A_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
                  op_b    = {{(MUL_B_W-GAIN_W){cfg.linear_gain[GAIN_W-1]}}, cfg.linear_gain};
                  gacc_in = gacc_ff - prod_g;
               end
               default: begin
                  gacc_in  = gacc_ff + prod_g;
                  state_in = ST_FILT;
                  step_in  = '0;
               end
            endcase
         end
         ST_FILT: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               3'd0: begin
                  op_a = s_now;
                  op_b = {{(MUL_B_W-COEF_W){cfg.coef_b0[COEF_W-1]}}, cfg.coef_b0};
                  s_in = s_now;
               end
               3'd1: begin
                  op_a    = sh2_ff;
                  op_b    = {{(MUL_B_W-COEF_W){cfg.coef_b2[COEF_W-1]}}, cfg.coef_b2};
                  facc_in = prod_f;
               end
               3'd2: begin
                  op_a    = oh1_ff;
                  op_b    = {{(MUL_B_W-COEF_W){cfg.coef_a1[COEF_W-1]}}, cfg.coef_a1};
                  facc_in = facc_ff + prod_f;
               end
               3'd3: begin
                  op_a    = oh2_ff;
                  op_b    = {{(MUL_B_W-COEF_W){cfg.coef_a2[COEF_W-1]}}, cfg.coef_a2};
                  facc_in = facc_ff + prod_f;
               end
               default: begin
                  facc_in  = facc_ff + prod_f;
                  state_in = ST_DONE;
                  step_in  = '0;
               end
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat24(y);
               sh2_in        = sh1_ff;
               sh1_in        = s_ff;
               oh2_in        = oh1_ff;
               oh1_in        = sat32(y);
               state_in      = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = x_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sh1_ff       <= '0;
         sh2_ff       <= '0;
         oh1_ff       <= '0;
         oh2_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sh1_ff       <= sh1_in;
         sh2_ff       <= sh2_in;
         oh1_ff       <= oh1_in;
         oh2_ff       <= oh2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      pow_ff        <= pow_in;
      cube_ff       <= cube_in;
      gacc_ff       <= gacc_in;
      facc_ff       <= facc_in;
      s_ff          <= s_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

// ===== rtl/core/radio_waveshaper_bandpass_core.sv =====
// channel | dir | ports                                            | handshake
// req     | in  | req_valid req_ready req_sample_in req_process_enable | valid/ready
// rsp     | out | rsp_valid rsp_ready rsp_sample_out               | valid/ready
// csr     | in  | csr_write_enable csr_index csr_write_data        | write strobe
//
// a request with the effect applied runs in the back end on the single 32x25
// multiplier, which does the power loop, the three gain products and the four
// filter taps in turn
// a passed-through request skips the multiplier in the back end
// the request queue keeps taking requests while the back end works or rsp stalls, until it is full
// synchronous reset clears queue, sequencer and filter histories and loads the config registers with their reset values
module radio_waveshaper_bandpass_core import rwb_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic                         req_process_enable,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_head_valid;
   entry_type q_head;
   logic      q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_POWER_GAIN:  cfg_in.power_gain     = csr_write_data[GAIN_W-1:0];
            REG_POWER_EXP:   cfg_in.power_exponent = csr_write_data[EXP_W-1:0];
            REG_CUBE_GAIN:   cfg_in.cube_gain      = csr_write_data[GAIN_W-1:0];
            REG_LINEAR_GAIN: cfg_in.linear_gain    = csr_write_data[GAIN_W-1:0];
            REG_COEF_B0:     cfg_in.coef_b0        = csr_write_data[COEF_W-1:0];
            REG_COEF_B2:     cfg_in.coef_b2        = csr_write_data[COEF_W-1:0];
            REG_COEF_A1:     cfg_in.coef_a1        = csr_write_data[COEF_W-1:0];
            REG_COEF_A2:     cfg_in.coef_a2        = csr_write_data[COEF_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_gain     <= POWER_GAIN_RST;
         cfg_ff.power_exponent <= POWER_EXP_RST;
         cfg_ff.cube_gain      <= CUBE_GAIN_RST;
         cfg_ff.linear_gain    <= LINEAR_GAIN_RST;
         cfg_ff.coef_b0        <= '0;
         cfg_ff.coef_b2        <= '0;
         cfg_ff.coef_a1        <= '0;
         cfg_ff.coef_a2        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rwb_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_in      (req_sample_in),
      .req_process_enable (req_process_enable),
      .pop                (q_pop),
      .head_valid         (q_head_valid),
      .head               (q_head)
   );

   rwb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (q_head_valid),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

   a_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("back end took a request from an empty queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_head_valid)
      else $error("accepted request missing from queue");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rwb_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 250;
   localparam int PHASES = 11;
   localparam int PHASE_ITEMS = 120;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SAMPLE_W-1:0]   req_sample_in;
   logic                         req_process_enable;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic                         csr_write_enable;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_write_data;

   cfg_type                      shape_cfg;
   logic signed [HIST_W-1:0]     shaped_d1, shaped_d2, filt_d1, filt_d2;
   logic signed [SAMPLE_W-1:0]   expected_samples[$];

   int  error_count = 0;
   int  stuck_cycles = 0;
   int  hold_requests = 0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_gaps_on = 1'b0;

   radio_waveshaper_bandpass_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_in      (req_sample_in),
      .req_process_enable (req_process_enable),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sample_out     (rsp_sample_out),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp(input longint v, input int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // repeated q1.23 multiply, each product floored back to q1.23
   function automatic longint raise_q23(input longint x, input int n);
      longint p;
      int k;
      p = longint'(1) <<< 23;
      for (k = 0; k < n; k++)
         p = (p * x) >>> 23;
      return p;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] bandpass_predict(
         input logic signed [SAMPLE_W-1:0] smp, input logic en);
      longint x, s, y, acc;
      if (!en || smp == 0) return smp;
      x = longint'(smp);
      acc = longint'($signed(shape_cfg.power_gain)) * raise_q23(x, shape_cfg.power_exponent)
          - longint'($signed(shape_cfg.cube_gain)) * raise_q23(x, 3)
          + longint'($signed(shape_cfg.linear_gain)) * x;
      s = acc >>> 12;
      acc = longint'($signed(shape_cfg.coef_b0)) * s
          + longint'($signed(shape_cfg.coef_b2)) * longint'(shaped_d2)
          + longint'($signed(shape_cfg.coef_a1)) * longint'(filt_d1)
          + longint'($signed(shape_cfg.coef_a2)) * longint'(filt_d2);
      y = acc >>> 16;
      shaped_d2 = shaped_d1;
      shaped_d1 = HIST_W'(clamp(s, HIST_W));
      filt_d2 = filt_d1;
      filt_d1 = HIST_W'(clamp(y, HIST_W));
      return SAMPLE_W'(clamp(y, SAMPLE_W));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         2, 3, 4: return SAMPLE_W'($signed($urandom_range(0, 131071)) - 65536);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type rand_config(input int kind);
      cfg_type c;
      c.power_gain = GAIN_W'($urandom);
      c.power_exponent = EXP_W'($urandom_range(0, 7));
      c.cube_gain = GAIN_W'($urandom);
      c.linear_gain = GAIN_W'($urandom);
      case (kind)
         0: begin
            // stable resonator style band-pass
            c.coef_b0 = COEF_W'($urandom_range(0, 20000));
            c.coef_b2 = -c.coef_b0;
            c.coef_a2 = COEF_W'(-$urandom_range(58000, 64000));
            c.coef_a1 = COEF_W'($urandom_range(60000, 126000));
         end
         1: begin
            c.coef_b0 = COEF_W'($urandom);
            c.coef_b2 = COEF_W'($urandom);
            c.coef_a1 = COEF_W'($urandom);
            c.coef_a2 = COEF_W'($urandom);
         end
         default: begin
            c.coef_b0 = COEF_ONE;
            c.coef_b2 = '0;
            c.coef_a1 = '0;
            c.coef_a2 = '0;
         end
      endcase
      return c;
   endfunction

   // unused upper data bits carry random junk
   task automatic load_config(input cfg_type c);
      logic [CSR_DATA_W-1:0] data;
      int r;
      for (r = 0; r < 8; r++) begin
         data = CSR_DATA_W'($urandom);
         case (CSR_IDX_W'(r))
            REG_POWER_GAIN:  data[GAIN_W-1:0] = c.power_gain;
            REG_POWER_EXP:   data[EXP_W-1:0] = c.power_exponent;
            REG_CUBE_GAIN:   data[GAIN_W-1:0] = c.cube_gain;
            REG_LINEAR_GAIN: data[GAIN_W-1:0] = c.linear_gain;
            REG_COEF_B0:     data = c.coef_b0;
            REG_COEF_B2:     data = c.coef_b2;
            REG_COEF_A1:     data = c.coef_a1;
            REG_COEF_A2:     data = c.coef_a2;
            default: ;
         endcase
         csr_write_enable <= 1'b1;
         csr_index <= CSR_IDX_W'(r);
         csr_write_data <= data;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      shape_cfg = c;
   endtask

   task automatic send_request(input logic signed [SAMPLE_W-1:0] smp, input logic en);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_process_enable <= en;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(bandpass_predict(smp, en));
   endtask

   task automatic settle(input int cycles);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   // zero coefficients after reset: every enabled request comes back as zero
   task automatic test_default_config();
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MIN, 1'b1);
      send_request(24'sd1, 1'b1);
      send_request(SAMPLE_MAX, 1'b0);
      settle(4);
   endtask

   task automatic test_extremes();
      cfg_type c;
      c.power_gain = POWER_GAIN_RST;
      c.power_exponent = POWER_EXP_RST;
      c.cube_gain = CUBE_GAIN_RST;
      c.linear_gain = LINEAR_GAIN_RST;
      c.coef_b0 = COEF_ONE;
      c.coef_b2 = '0;
      c.coef_a1 = '0;
      c.coef_a2 = '0;
      load_config(c);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MIN, 1'b1);
      send_request(-24'sd1, 1'b1);
      send_request(24'sd1, 1'b1);
      send_request('0, 1'b1);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(24'sh5A5A5A, 1'b0);
      settle(4);

      // exponent zero turns the power term into a constant offset
      c.power_gain = 16'sh7FFF;
      c.power_exponent = '0;
      c.cube_gain = 16'sh8000;
      c.linear_gain = 16'sh7FFF;
      c.coef_b0 = 20'sh80000;
      c.coef_b2 = 20'sh7FFFF;
      c.coef_a1 = 20'sh7FFFF;
      c.coef_a2 = 20'sh80000;
      load_config(c);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MIN, 1'b1);
      send_request(24'sd1, 1'b1);
      send_request(-24'sd1, 1'b1);
      send_request(24'sh400000, 1'b1);
      settle(4);

      c.power_gain = 16'sh8000;
      c.power_exponent = 3'd7;
      c.cube_gain = 16'sh7FFF;
      c.linear_gain = 16'sh8000;
      load_config(c);
      send_request(SAMPLE_MIN, 1'b1);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(24'shC00000, 1'b1);
      send_request(SAMPLE_MAX, 1'b1);
      settle(4);
   endtask

   task automatic test_random_phases();
      int p, n;
      for (p = 0; p < PHASES; p++) begin
         req_gaps_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
         load_config(rand_config(p % 3));
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(rand_sample(), $urandom_range(0, 9) != 0);
         settle(4);
      end
   endtask

   // receiver holds off while requests keep coming so the queue backs up
   task automatic test_backpressure();
      int n;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b1;
      load_config(rand_config(0));
      hold_requests++;
      for (n = 0; n < 40; n++)
         send_request(rand_sample(), $urandom_range(0, 7) != 0);
      settle(4);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_in <= '0;
      req_process_enable <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      shape_cfg.power_gain = POWER_GAIN_RST;
      shape_cfg.power_exponent = POWER_EXP_RST;
      shape_cfg.cube_gain = CUBE_GAIN_RST;
      shape_cfg.linear_gain = LINEAR_GAIN_RST;
      shape_cfg.coef_b0 = '0;
      shape_cfg.coef_b2 = '0;
      shape_cfg.coef_a1 = '0;
      shape_cfg.coef_a2 = '0;
      shaped_d1 = '0;
      shaped_d2 = '0;
      filt_d1 = '0;
      filt_d2 = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_config();
      test_extremes();
      test_random_phases();
      test_backpressure();
      settle(30);

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // response side: check, then draw the stall before the next response
   initial begin
      int stall_left, hold_left, holds_served;
      logic signed [SAMPLE_W-1:0] want;
      stall_left = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %0d",
                        $time, rsp_sample_out);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d actual %0d",
                           $time, want, rsp_sample_out);
                  error_count++;
               end
            end
            stall_left = rsp_gaps_on ? $urandom_range(0, 19) : 0;
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
rtl/core/rwb_pkg.sv
rtl/core/rwb_front.sv
rtl/core/rwb_back.sv
rtl/core/radio_waveshaper_bandpass_core.sv
sim/tb_top.sv
